[hw/rtl/amo_pkg.sv]
// Package for the atomic memory operation unit: payload structs, command
// codes, controller states and command/status structs. No dependencies.
package amo_pkg;
  localparam int MemBytes = 65536;
  localparam int WordCount = (MemBytes + 7) / 8;
  localparam int WAddrW = $clog2(WordCount);
  localparam int ClrW = WAddrW + 1;

  typedef enum logic [3:0] {
    CMD_LOAD = 4'd0, CMD_STORE = 4'd1, CMD_ADD = 4'd2, CMD_SUB = 4'd3,
    CMD_AND = 4'd4, CMD_OR = 4'd5, CMD_XOR = 4'd6, CMD_XCHG = 4'd7,
    CMD_CMPXCHG = 4'd8
  } cmd_t;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StUnaligned = 2'd1;
  localparam logic [1:0] StBounds = 2'd2;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [1:0]  size_code;
    logic        sign_extend;
    logic        result_wide;
    logic        atomic_check;
    logic [31:0] address;
    logic [63:0] operand_value;
    logic [63:0] compare_value;
  } amo_in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  status;
  } amo_out_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_READ2, S_EXEC, S_WRHI, S_OUT
  } amo_state_t;

  typedef struct packed {
    logic clr_en;
    logic capture;
    logic rd_en;
    logic rd_hi;
    logic exec;
    logic wr_hi;
  } amo_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic needs_mem;
    logic crosses;
  } amo_stat_t;
endpackage

[hw/rtl/atomic_memory_op_unit.sv]
// Top level of the atomic memory operation unit: controller plus datapath.
// Uses amo_pkg, amo_ctrl and amo_dp.
//
//   channel  dir  handshake             word
//   in_      in   in_valid/in_ready     amo_in_t
//   out_     out  out_valid/out_ready   amo_out_t
//
// An access within one memory word passes through accept, memory read,
// execute/write and output; one whose bytes span two words adds an extra
// read and an extra write. A trapped or unused command goes from read to output.
// The single memory port sets these steps. After reset a clearing pass zeroes 8192
// words, one per cycle, before the first word is accepted. A stalled result
// holds the unit in its output state.
module atomic_memory_op_unit import amo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  amo_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output amo_out_t out_data
);
  amo_cmd_t  cmd;
  amo_stat_t stat;

  amo_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
                   .stat, .cmd);
  amo_dp u_dp (.clk, .rst_n, .in_data, .cmd, .stat, .out_data);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !stat.crosses) || cmd.wr_hi |=> out_valid)
    else $error("no result after execute");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
endmodule

[hw/rtl/amo_ctrl.sv]
// Controller for the atomic memory operation unit: clearing pass, then one
// word at a time through read, execute and output. Uses amo_pkg.
module amo_ctrl import amo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  amo_stat_t stat,
  output amo_cmd_t  cmd
);
  amo_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (!stat.needs_mem) state_nxt = S_OUT;
        else state_nxt = stat.crosses ? S_READ2 : S_EXEC;
      end
      // An access whose bytes span two memory words also reads the upper word.
      S_READ2: begin
        cmd.rd_hi = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = stat.crosses ? S_WRHI : S_OUT;
      end
      S_WRHI: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end
endmodule

[hw/rtl/amo_dp.sv]
// Datapath for the atomic memory operation unit: word memory, checks,
// byte lane merge and result formatting. Uses amo_pkg.
module amo_dp import amo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  amo_in_t   in_data,
  input  amo_cmd_t  cmd,
  output amo_stat_t stat,
  output amo_out_t  out_data
);
  logic [63:0] mem [WordCount];
  logic [ClrW-1:0] clr_cnt_r;
  amo_in_t req_r;
  logic [63:0] rdw_r, rdh_r;
  logic [63:0] res_r, res_nxt;
  logic [1:0] st_r, st_nxt;
  logic [32:0] end_addr;
  logic [3:0] nbytes;
  logic [63:0] mask, old, opv, cmpv, newv;
  logic [127:0] win, win_sh, lmask_w, new_w;
  logic [WAddrW-1:0] widx, widx_hi;
  logic [5:0] sh;
  logic need_align, unal, oob, valid_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_en && !clr_cnt_r[ClrW-1]) clr_cnt_r <= clr_cnt_r + 1'b1;
  end
  assign stat.clr_done = (clr_cnt_r == ClrW'(WordCount - 1)) || clr_cnt_r[ClrW-1];

  assign nbytes = 4'd1 << req_r.size_code;
  assign mask = (req_r.size_code == 2'd3) ? '1 : ((64'd1 << {nbytes, 3'd0}) - 64'd1);
  assign end_addr = {1'b0, req_r.address} + 33'(nbytes);
  assign oob = end_addr > 33'(MemBytes);
  assign valid_cmd = req_r.cmd <= 4'(CMD_CMPXCHG);
  assign need_align = (req_r.cmd >= 4'(CMD_ADD)) || req_r.atomic_check;
  assign unal = need_align && ((req_r.address[2:0] & 3'(nbytes - 4'd1)) != 3'd0);
  assign stat.needs_mem = valid_cmd && !oob && !unal;
  assign stat.crosses = (4'(req_r.address[2:0]) + nbytes) > 4'd8;

  assign widx = req_r.address[WAddrW+2:3];
  assign widx_hi = widx + WAddrW'(1);

  // The two words around the access form one 128-bit window.
  assign win = {rdh_r, rdw_r};
  assign sh = {req_r.address[2:0], 3'd0};
  assign win_sh = win >> sh;
  assign old = win_sh[63:0] & mask;
  assign opv = req_r.operand_value & mask;
  assign cmpv = req_r.compare_value & mask;
  assign lmask_w = {64'd0, mask} << sh;

  always_comb begin
    newv = old;
    unique case (req_r.cmd)
      4'(CMD_STORE), 4'(CMD_XCHG): newv = opv;
      4'(CMD_ADD): newv = (old + opv) & mask;
      4'(CMD_SUB): newv = (old - opv) & mask;
      4'(CMD_AND): newv = old & opv;
      4'(CMD_OR):  newv = old | opv;
      4'(CMD_XOR): newv = old ^ opv;
      4'(CMD_CMPXCHG): newv = (old == cmpv) ? opv : old;
      default: newv = old;
    endcase
    new_w = (win & ~lmask_w) | (({64'd0, newv} << sh) & lmask_w);
  end

  always_comb begin
    res_nxt = old;
    if (req_r.cmd == 4'(CMD_STORE)) res_nxt = '0;
    else if (req_r.cmd == 4'(CMD_LOAD) && req_r.sign_extend && req_r.size_code != 2'd3
             && ((old & ~(mask >> 1)) != 64'd0)) res_nxt = old | ~mask;
    if (!req_r.result_wide) res_nxt[63:32] = '0;
    st_nxt = StOk;
    if (valid_cmd && oob) st_nxt = StBounds;
    else if (valid_cmd && unal) st_nxt = StUnaligned;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en && !clr_cnt_r[ClrW-1])
      mem[clr_cnt_r[WAddrW-1:0]] <= '0;
    else if (cmd.exec)
      mem[widx] <= new_w[63:0];
    else if (cmd.wr_hi)
      mem[widx_hi] <= new_w[127:64];
    if (cmd.rd_en) rdw_r <= mem[widx];
    if (cmd.rd_hi) rdh_r <= mem[widx_hi];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.rd_en) begin
      st_r <= (valid_cmd && oob) ? StBounds : ((valid_cmd && unal) ? StUnaligned : StOk);
      res_r <= '0;
    end
    if (cmd.exec) begin
      st_r <= st_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_data.read_data = res_r;
  assign out_data.status = st_r;
endmodule

[bench/amo_checker.sv]
// Checker for the atomic memory operation unit: watches both channels,
// predicts each result from its own byte memory and compares. Uses amo_pkg.
`timescale 1ns / 100ps
module amo_checker import amo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  amo_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  amo_out_t out_data,
  output int       fail_count,
  output int       pending
);
  logic [63:0] mem_image [WordCount];
  amo_out_t expected_words [$];

  assign pending = expected_words.size();

  function automatic logic [63:0] load_bytes(logic [31:0] addr, int nbytes);
    logic [63:0] v;
    logic [31:0] a;
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      a = addr + i;
      v[i*8 +: 8] = mem_image[a[31:3] % WordCount][a[2:0]*8 +: 8];
    end
    return v;
  endfunction

  task automatic store_bytes(logic [31:0] addr, int nbytes, logic [63:0] v);
    logic [31:0] a;
    for (int i = 0; i < nbytes; i++) begin
      a = addr + i;
      mem_image[a[31:3] % WordCount][a[2:0]*8 +: 8] = v[i*8 +: 8];
    end
  endtask

  task automatic predict_access(amo_in_t w);
    amo_out_t r;
    int nbytes;
    logic [63:0] mask, opv, cmpv, old;
    logic need_align;
    nbytes = 1 << w.size_code;
    mask = (nbytes == 8) ? '1 : ((64'd1 << (nbytes * 8)) - 1);
    opv = w.operand_value & mask;
    cmpv = w.compare_value & mask;
    r.read_data = '0;
    r.status = StOk;
    if (w.cmd <= CMD_CMPXCHG) begin
      need_align = (w.cmd >= CMD_ADD) || w.atomic_check;
      if ({32'd0, w.address} + nbytes > MemBytes) begin
        r.status = StBounds;
      end else if (need_align && ((w.address & (nbytes - 1)) != 0)) begin
        r.status = StUnaligned;
      end else begin
        old = load_bytes(w.address, nbytes);
        r.read_data = old;
        case (cmd_t'(w.cmd))
          CMD_LOAD: begin
            if (w.sign_extend && nbytes < 8 && old[nbytes*8-1]) r.read_data = old | ~mask;
          end
          CMD_STORE: begin
            r.read_data = '0;
            store_bytes(w.address, nbytes, opv);
          end
          CMD_ADD: store_bytes(w.address, nbytes, (old + opv) & mask);
          CMD_SUB: store_bytes(w.address, nbytes, (old - opv) & mask);
          CMD_AND: store_bytes(w.address, nbytes, old & opv);
          CMD_OR: store_bytes(w.address, nbytes, old | opv);
          CMD_XOR: store_bytes(w.address, nbytes, old ^ opv);
          CMD_XCHG: store_bytes(w.address, nbytes, opv);
          default: begin
            if (old == cmpv) store_bytes(w.address, nbytes, opv);
          end
        endcase
        if (!w.result_wide) r.read_data[63:32] = '0;
      end
    end
    expected_words.push_back(r);
  endtask

  always @(posedge clk) begin
    amo_out_t e;
    if (!rst_n) begin
      fail_count = 0;
      foreach (mem_image[i]) mem_image[i] = '0;
    end else begin
      if (in_valid && in_ready) predict_access(in_data);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          if (out_data.read_data !== e.read_data) begin
            $error("read_data expected %h actual %h", e.read_data, out_data.read_data);
            fail_count++;
          end
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[bench/tb_atomic_memory_op_unit.sv]
// Testbench top for the atomic memory operation unit: makes clock, reset,
// stimulus and verdict. Uses amo_pkg, atomic_memory_op_unit and amo_checker.
`timescale 1ns / 100ps
module tb_atomic_memory_op_unit;
  import amo_pkg::*;

  localparam int IdleLimit = 50000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  amo_in_t in_data;
  amo_out_t out_data;
  int fail_count, pending, idle_cycles;
  logic steady;

  atomic_memory_op_unit uut (.*);
  amo_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side stalls at random except in the steady stretch.
  always @(negedge clk) out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 16);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_access(logic [3:0] cmd, logic [1:0] sz, logic [31:0] addr,
                             logic [63:0] opv, logic [63:0] cmpv,
                             logic sext, logic wide, logic achk);
    amo_in_t w;
    w.cmd = cmd;
    w.size_code = sz;
    w.sign_extend = sext;
    w.result_wide = wide;
    w.atomic_check = achk;
    w.address = addr;
    w.operand_value = opv;
    w.compare_value = cmpv;
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Small compare values so compare-exchange often finds a match in fresh memory.
  function automatic logic [63:0] load_guess();
    return $urandom_range(1) ? 64'd0 : 64'($urandom_range(3));
  endfunction

  // Mostly aligned addresses within a small window so accesses hit the same words.
  function automatic logic [31:0] pick_addr(logic [1:0] sz);
    int r;
    logic [31:0] a;
    r = $urandom_range(99);
    if (r < 70) a = $urandom_range(63) << sz;
    else if (r < 80) a = $urandom_range(MemBytes - 1);
    else if (r < 88) a = MemBytes - $urandom_range(8);
    else if (r < 94) a = $urandom;
    else a = $urandom_range(255);
    return a;
  endfunction

  initial begin
    logic [1:0] sz;
    logic [3:0] cmd;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every command, traps, sign extension, unused codes.
    send_access(CMD_LOAD, 2'd3, 32'd0, '0, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_STORE, 2'd3, 32'd8, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b1, 1'b1);
    send_access(CMD_LOAD, 2'd0, 32'd9, '0, '0, 1'b1, 1'b1, 1'b0);
    send_access(CMD_LOAD, 2'd1, 32'd9, '0, '0, 1'b1, 1'b0, 1'b0);
    send_access(CMD_LOAD, 2'd2, 32'd10, '0, '0, 1'b0, 1'b1, 1'b1);
    send_access(CMD_LOAD, 2'd3, 32'd8, '0, '0, 1'b1, 1'b0, 1'b0);
    send_access(CMD_ADD, 2'd2, 32'd16, 64'hFFFF_FFFF_8000_0001, '0, 1'b1, 1'b1, 1'b0);
    send_access(CMD_SUB, 2'd2, 32'd16, 64'd5, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_AND, 2'd1, 32'd16, 64'h0F0F, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_OR, 2'd0, 32'd17, 64'hA5, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_XOR, 2'd3, 32'd16, 64'h1234_5678_9ABC_DEF0, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_XCHG, 2'd3, 32'd16, 64'h8000_0000_0000_0000, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_CMPXCHG, 2'd3, 32'd16, 64'd7, 64'h8000_0000_0000_0000,
                1'b0, 1'b1, 1'b0);
    send_access(CMD_CMPXCHG, 2'd3, 32'd16, 64'd9, 64'd8, 1'b0, 1'b1, 1'b0);
    send_access(CMD_ADD, 2'd2, 32'd18, 64'd1, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_LOAD, 2'd2, 32'd18, '0, '0, 1'b0, 1'b1, 1'b1);
    send_access(CMD_STORE, 2'd3, 32'd3, 64'h55, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_LOAD, 2'd3, 32'd5, '0, '0, 1'b1, 1'b1, 1'b0);
    send_access(CMD_LOAD, 2'd3, MemBytes - 8, '0, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_LOAD, 2'd3, MemBytes - 7, '0, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_STORE, 2'd0, 32'hFFFF_FFFF, 64'h1, '0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_XOR, 2'd3, 32'hFFFF_FFF9, 64'h1, '0, 1'b0, 1'b1, 1'b0);
    send_access(4'd9, 2'd0, 32'd0, '0, '0, 1'b0, 1'b1, 1'b0);
    send_access(4'd15, 2'd3, 32'hFFFF_FFFF, '1, '1, 1'b1, 1'b1, 1'b1);

    for (int n = 0; n < 1300; n++) begin
      steady = (n >= 500 && n < 700);
      sz = 2'($urandom_range(3));
      cmd = ($urandom_range(99) < 95) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
      send_access(cmd, sz, pick_addr(sz), rand64(),
                  ($urandom_range(1) ? rand64() : load_guess()),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
